@@ hw/rtl/ssi_pkg.sv @@
// Shared types and constants for the segment-segment intersection pipeline.
// No dependencies; imported by every module of the block.
package ssi_pkg;

    // Default coordinate width of the input and result points
    localparam int CoordWidthDefault = 16;

    // Where a result point comes from
    typedef enum logic [1:0] {
        SRC_A   = 2'd0,
        SRC_B   = 2'd1,
        SRC_DIV = 2'd2
    } ssi_src_t;

    // Decision made for one item, carried alongside the divider
    typedef struct packed {
        logic     hit;
        logic     has_far;
        ssi_src_t near_src;
        ssi_src_t far_src;
    } ssi_ctrl_t;

endpackage

@@ hw/rtl/ssi_front.sv @@
// Front end of the intersection pipeline: differences, cross and dot products,
// sums and case selection over five register stages. Depends on ssi_pkg.
module ssi_front
    import ssi_pkg::*;
#(
    parameter int W = CoordWidthDefault
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   a_x,
    input  logic signed [W-1:0]   a_y,
    input  logic signed [W-1:0]   b_x,
    input  logic signed [W-1:0]   b_y,
    input  logic signed [W-1:0]   c_x,
    input  logic signed [W-1:0]   c_y,
    input  logic signed [W-1:0]   d_x,
    input  logic signed [W-1:0]   d_y,
    output logic                  valid,
    output ssi_ctrl_t             ctrl,
    output logic [2*W:0]          ud,
    output logic [2*W:0]          un_n,
    output logic [2*W:0]          un_f,
    output logic [W-1:0]          ub_x,
    output logic [W-1:0]          ub_y,
    output logic [3:0]            neg,
    output logic signed [W-1:0]   ax,
    output logic signed [W-1:0]   ay,
    output logic signed [W-1:0]   bx,
    output logic signed [W-1:0]   by
);

    localparam int DW  = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int SW  = 2 * W + 3;
    localparam int UD  = 2 * W + 1;
    localparam int CVW = 6 * W + 2;

    // stage valid bits
    logic [4:0] v_reg;

    // stage 1: differences
    logic signed [DW-1:0] rx_reg, ry_reg, sx_reg, sy_reg, qx_reg, qy_reg;
    logic signed [DW-1:0] rx_next, ry_next, sx_next, sy_next, qx_next, qy_next;
    logic [4*W-1:0]       pts_reg;

    // stage 2: products
    logic signed [PW-1:0] prs1_reg, prs2_reg, pqr1_reg, pqr2_reg, pqs1_reg, pqs2_reg;
    logic signed [PW-1:0] prr1_reg, prr2_reg, psr1_reg, psr2_reg, pt1_reg, pt2_reg;
    logic [W-1:0]         mx_next, my_next;
    logic [CVW-1:0]       cv2_reg, cv2_next;

    // stage 3: sums
    logic signed [SW-1:0] rs_reg, qr_reg, qs_reg, rr_reg, sr_reg, t0_reg;
    logic [CVW-1:0]       cv3_reg;

    // stage 4: parallel test, collinear ordering
    logic signed [SW-1:0] t1_next, lo_next, hi_next, mrs_next, mqs_next, mqr_next;
    logic signed [SW-1:0] lo_reg, hi_reg, rr4_reg, mrs_reg, mqs_reg;
    logic                 np_hit_next, par_reg, np_hit_reg, coll_reg, nneg_reg;
    logic [CVW-1:0]       cv4_reg;

    // stage 5: case selection
    ssi_ctrl_t            ctrl_next, ctrl_reg;
    logic                 n0in, n1in, lo_le0, hi_ger;
    logic [UD-1:0]        ud_reg, un_n_reg, un_f_reg;
    logic [3:0]           neg_next, neg_reg;
    logic [CVW-1:0]       cv5_reg;
    logic                 rxn4, ryn4;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // stage 1
    assign rx_next = DW'(b_x) - DW'(a_x);
    assign ry_next = DW'(b_y) - DW'(a_y);
    assign sx_next = DW'(d_x) - DW'(c_x);
    assign sy_next = DW'(d_y) - DW'(c_y);
    assign qx_next = DW'(c_x) - DW'(a_x);
    assign qy_next = DW'(c_y) - DW'(a_y);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            pts_reg <= {a_x, a_y, b_x, b_y};
        end
    end

    // stage 2: one multiplier per product
    assign mx_next  = rx_reg[DW-1] ? W'(-rx_reg) : W'(rx_reg);
    assign my_next  = ry_reg[DW-1] ? W'(-ry_reg) : W'(ry_reg);
    assign cv2_next = {pts_reg, mx_next, my_next, rx_reg[DW-1], ry_reg[DW-1]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prs1_reg <= PW'(rx_reg) * PW'(sy_reg);
            prs2_reg <= PW'(ry_reg) * PW'(sx_reg);
            pqr1_reg <= PW'(qx_reg) * PW'(ry_reg);
            pqr2_reg <= PW'(qy_reg) * PW'(rx_reg);
            pqs1_reg <= PW'(qx_reg) * PW'(sy_reg);
            pqs2_reg <= PW'(qy_reg) * PW'(sx_reg);
            prr1_reg <= PW'(rx_reg) * PW'(rx_reg);
            prr2_reg <= PW'(ry_reg) * PW'(ry_reg);
            psr1_reg <= PW'(sx_reg) * PW'(rx_reg);
            psr2_reg <= PW'(sy_reg) * PW'(ry_reg);
            pt1_reg  <= PW'(qx_reg) * PW'(rx_reg);
            pt2_reg  <= PW'(qy_reg) * PW'(ry_reg);
            cv2_reg  <= cv2_next;
        end
    end

    // stage 3: cross and dot products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_reg  <= SW'(prs1_reg) - SW'(prs2_reg);
            qr_reg  <= SW'(pqr1_reg) - SW'(pqr2_reg);
            qs_reg  <= SW'(pqs1_reg) - SW'(pqs2_reg);
            rr_reg  <= SW'(prr1_reg) + SW'(prr2_reg);
            sr_reg  <= SW'(psr1_reg) + SW'(psr2_reg);
            t0_reg  <= SW'(pt1_reg) + SW'(pt2_reg);
            cv3_reg <= cv2_reg;
        end
    end

    // stage 4: order the collinear parameters, test the non-parallel hit
    assign t1_next  = t0_reg + sr_reg;
    assign lo_next  = sr_reg[SW-1] ? t1_next : t0_reg;
    assign hi_next  = sr_reg[SW-1] ? t0_reg : t1_next;
    assign mrs_next = rs_reg[SW-1] ? -rs_reg : rs_reg;
    assign mqs_next = qs_reg[SW-1] ? -qs_reg : qs_reg;
    assign mqr_next = qr_reg[SW-1] ? -qr_reg : qr_reg;
    assign np_hit_next = (qs_reg == '0 || qs_reg[SW-1] == rs_reg[SW-1]) &&
                         (mrs_next >= mqs_next) &&
                         (qr_reg == '0 || qr_reg[SW-1] == rs_reg[SW-1]) &&
                         (mrs_next >= mqr_next);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            rr4_reg    <= rr_reg;
            mrs_reg    <= mrs_next;
            mqs_reg    <= mqs_next;
            par_reg    <= (rs_reg == '0);
            np_hit_reg <= np_hit_next;
            coll_reg   <= (qr_reg == '0) && (rr_reg != '0);
            nneg_reg   <= qs_reg[SW-1] ^ rs_reg[SW-1];
            cv4_reg    <= cv3_reg;
        end
    end

    // stage 5: pick the case and set up the divider lanes
    assign n0in   = !lo_reg[SW-1] && (lo_reg <= rr4_reg);
    assign n1in   = !hi_reg[SW-1] && (hi_reg <= rr4_reg);
    assign lo_le0 = lo_reg[SW-1] || (lo_reg == '0);
    assign hi_ger = (hi_reg >= rr4_reg);
    assign rxn4   = cv4_reg[1];
    assign ryn4   = cv4_reg[0];

    always_comb
    begin
        ctrl_next.hit      = 1'b0;
        ctrl_next.has_far  = 1'b0;
        ctrl_next.near_src = SRC_DIV;
        ctrl_next.far_src  = SRC_DIV;
        if (par_reg)
        begin
            if (coll_reg)
            begin
                if (n0in && hi_ger)
                begin
                    ctrl_next.hit      = 1'b1;
                    ctrl_next.near_src = SRC_DIV;
                    ctrl_next.far_src  = SRC_B;
                end
                else if (lo_le0 && n1in)
                begin
                    ctrl_next.hit      = 1'b1;
                    ctrl_next.near_src = SRC_A;
                    ctrl_next.far_src  = SRC_DIV;
                end
                else if (n0in && n1in)
                begin
                    ctrl_next.hit      = 1'b1;
                    ctrl_next.near_src = SRC_DIV;
                    ctrl_next.far_src  = SRC_DIV;
                end
                else if (lo_le0 && hi_ger)
                begin
                    ctrl_next.hit      = 1'b1;
                    ctrl_next.near_src = SRC_A;
                    ctrl_next.far_src  = SRC_B;
                end
            end
            ctrl_next.has_far = ctrl_next.hit;
        end
        else
        begin
            ctrl_next.hit = np_hit_reg;
        end
    end

    // lanes: near x, near y, far x, far y
    assign neg_next = {ryn4, rxn4,
                       (!par_reg && nneg_reg) ^ ryn4,
                       (!par_reg && nneg_reg) ^ rxn4};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctrl_reg <= ctrl_next;
            ud_reg   <= par_reg ? UD'(rr4_reg) : UD'(mrs_reg);
            un_n_reg <= par_reg ? UD'(lo_reg) : UD'(mqs_reg);
            un_f_reg <= UD'(hi_reg);
            neg_reg  <= neg_next;
            cv5_reg  <= cv4_reg;
        end
    end

    assign valid = v_reg[4];
    assign ctrl  = ctrl_reg;
    assign ud    = ud_reg;
    assign un_n  = un_n_reg;
    assign un_f  = un_f_reg;
    assign neg   = neg_reg;
    assign ub_x  = cv5_reg[2*W+1 -: W];
    assign ub_y  = cv5_reg[W+1 -: W];
    assign ax    = cv5_reg[6*W+1 -: W];
    assign ay    = cv5_reg[5*W+1 -: W];
    assign bx    = cv5_reg[4*W+1 -: W];
    assign by    = cv5_reg[3*W+1 -: W];

endmodule

@@ hw/rtl/ssi_div_step.sv @@
// One radix-2 step of the scaled division round(un*ub/ud), four lanes at once,
// with the item's side data carried along. Depends on ssi_pkg.
module ssi_div_step
    import ssi_pkg::*;
#(
    parameter int W      = CoordWidthDefault,
    parameter int SIDE_W = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [2*W:0]            ud,
    input  logic [2*W:0]            un_n,
    input  logic [2*W:0]            un_f,
    input  logic [W-1:0]            ub_x,
    input  logic [W-1:0]            ub_y,
    input  logic [3:0][2*W:0]       rem,
    input  logic [3:0][W-1:0]       q,
    input  logic [SIDE_W-1:0]       side,
    output logic                    out_valid,
    output logic [2*W:0]            out_ud,
    output logic [2*W:0]            out_un_n,
    output logic [2*W:0]            out_un_f,
    output logic [W-1:0]            out_ub_x,
    output logic [W-1:0]            out_ub_y,
    output logic [3:0][2*W:0]       out_rem,
    output logic [3:0][W-1:0]       out_q,
    output logic [SIDE_W-1:0]       out_side
);

    localparam int UD = 2 * W + 1;
    localparam int RW = 2 * W + 3;

    logic                valid_reg;
    logic [UD-1:0]       ud_reg, un_n_reg, un_f_reg;
    logic [W-1:0]        ub_x_reg, ub_y_reg;
    logic [3:0][UD-1:0]  rem_reg, rem_next;
    logic [3:0][W-1:0]   q_reg, q_next;
    logic [SIDE_W-1:0]   side_reg;
    logic [3:0][RW-1:0]  acc;
    logic [3:0][1:0]     dig;
    logic [RW-1:0]       ud1, ud2;

    assign ud1 = RW'(ud);
    assign ud2 = RW'({ud, 1'b0});

    // shift in one multiplier bit, take out up to two divisors
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            acc[l] = RW'({rem[l], 1'b0});
            if ((l % 2 == 0) ? ub_x[W-1] : ub_y[W-1])
            begin
                acc[l] = acc[l] + RW'((l < 2) ? un_n : un_f);
            end
            if (acc[l] >= ud2)
            begin
                rem_next[l] = UD'(acc[l] - ud2);
                dig[l]      = 2'd2;
            end
            else if (acc[l] >= ud1)
            begin
                rem_next[l] = UD'(acc[l] - ud1);
                dig[l]      = 2'd1;
            end
            else
            begin
                rem_next[l] = UD'(acc[l]);
                dig[l]      = 2'd0;
            end
            q_next[l] = {q[l][W-2:0], 1'b0} + W'(dig[l]);
        end
    end

    // advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // hold the lane data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ud_reg   <= ud;
            un_n_reg <= un_n;
            un_f_reg <= un_f;
            ub_x_reg <= {ub_x[W-2:0], 1'b0};
            ub_y_reg <= {ub_y[W-2:0], 1'b0};
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            side_reg <= side;
        end
    end

    assign out_valid = valid_reg;
    assign out_ud    = ud_reg;
    assign out_un_n  = un_n_reg;
    assign out_un_f  = un_f_reg;
    assign out_ub_x  = ub_x_reg;
    assign out_ub_y  = ub_y_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

@@ hw/rtl/segment_segment_intersection.sv @@
// Top level of the segment-segment intersection block: front end, divider
// chain, rounding and output register. Depends on ssi_pkg, ssi_front, ssi_div_step.
//
// Usage:
//  Input channel in_valid/in_stall carries one segment pair (A,B,C,D) per item.
//  Output channel out_valid/out_stall carries hit, near point, has_far and far
//  point. An item is moved at a clock edge with valid high and stall low.
//  The pipeline runs through five front stages, one divider step per
//  coordinate bit, one rounding stage and the output register. Throughput is
//  one item per cycle while the output is not stalled; every stage is a fixed
//  register slot, so a new pair may enter on every clock with in_stall low.
//  When the receiver stalls a valid result, the whole pipeline holds and
//  in_stall rises in the same cycle; nothing is dropped or repeated, and the
//  result stays on the output ports until taken.
//  Reset (rst_n low, asynchronous) empties the pipeline: all valid bits clear,
//  out_valid falls and the next pair may be offered right after release.
//  With no hit all point fields read zero; the far point reads zero unless
//  has_far.
module segment_segment_intersection
    import ssi_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDefault
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] d_x,
    input  logic signed [COORD_WIDTH-1:0] d_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] near_x,
    output logic signed [COORD_WIDTH-1:0] near_y,
    output logic                          has_far,
    output logic signed [COORD_WIDTH-1:0] far_x,
    output logic signed [COORD_WIDTH-1:0] far_y
);

    localparam int W      = COORD_WIDTH;
    localparam int UD     = 2 * W + 1;
    localparam int CTW    = $bits(ssi_ctrl_t);
    localparam int SIDE_W = 4 * W + 4 + CTW;
    localparam int VW     = W + 2;

    logic adv;

    // front end outputs
    logic                 f_valid;
    ssi_ctrl_t            f_ctrl;
    logic [UD-1:0]        f_ud, f_un_n, f_un_f;
    logic [W-1:0]         f_ub_x, f_ub_y;
    logic [3:0]           f_neg;
    logic signed [W-1:0]  f_ax, f_ay, f_bx, f_by;

    // divider chain
    logic                 ch_valid [W+1];
    logic [UD-1:0]        ch_ud    [W+1];
    logic [UD-1:0]        ch_un_n  [W+1];
    logic [UD-1:0]        ch_un_f  [W+1];
    logic [W-1:0]         ch_ub_x  [W+1];
    logic [W-1:0]         ch_ub_y  [W+1];
    logic [3:0][UD-1:0]   ch_rem   [W+1];
    logic [3:0][W-1:0]    ch_q     [W+1];
    logic [SIDE_W-1:0]    ch_side  [W+1];

    // rounding stage
    logic                 rv_reg;
    logic [3:0][VW-1:0]   v_reg, v_next;
    logic [SIDE_W-1:0]    rside_reg;
    logic [3:0]           d_neg;
    logic [3:0]           rnd;
    logic [3:0][W:0]      qq;

    // output stage
    ssi_ctrl_t            o_ctrl;
    logic signed [W-1:0]  o_ax, o_ay, o_bx, o_by;
    logic [3:0][W-1:0]    pt;
    logic signed [W-1:0]  near_x_next, near_y_next, far_x_next, far_y_next;
    logic                 out_valid_reg, hit_reg, has_far_reg;
    logic signed [W-1:0]  near_x_reg, near_y_reg, far_x_reg, far_y_reg;

    // the pipeline moves unless a finished item is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    ssi_front #(
        .W (W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .a_x      (a_x),
        .a_y      (a_y),
        .b_x      (b_x),
        .b_y      (b_y),
        .c_x      (c_x),
        .c_y      (c_y),
        .d_x      (d_x),
        .d_y      (d_y),
        .valid    (f_valid),
        .ctrl     (f_ctrl),
        .ud       (f_ud),
        .un_n     (f_un_n),
        .un_f     (f_un_f),
        .ub_x     (f_ub_x),
        .ub_y     (f_ub_y),
        .neg      (f_neg),
        .ax       (f_ax),
        .ay       (f_ay),
        .bx       (f_bx),
        .by       (f_by)
    );

    assign ch_valid[0] = f_valid;
    assign ch_ud[0]    = f_ud;
    assign ch_un_n[0]  = f_un_n;
    assign ch_un_f[0]  = f_un_f;
    assign ch_ub_x[0]  = f_ub_x;
    assign ch_ub_y[0]  = f_ub_y;
    assign ch_rem[0]   = '0;
    assign ch_q[0]     = '0;
    assign ch_side[0]  = {f_ax, f_ay, f_bx, f_by, f_neg, f_ctrl};

    // one divider step per coordinate bit
    for (genvar k = 0; k < W; k++)
    begin : g_step
        ssi_div_step #(
            .W      (W),
            .SIDE_W (SIDE_W)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (ch_valid[k]),
            .ud        (ch_ud[k]),
            .un_n      (ch_un_n[k]),
            .un_f      (ch_un_f[k]),
            .ub_x      (ch_ub_x[k]),
            .ub_y      (ch_ub_y[k]),
            .rem       (ch_rem[k]),
            .q         (ch_q[k]),
            .side      (ch_side[k]),
            .out_valid (ch_valid[k+1]),
            .out_ud    (ch_ud[k+1]),
            .out_un_n  (ch_un_n[k+1]),
            .out_un_f  (ch_un_f[k+1]),
            .out_ub_x  (ch_ub_x[k+1]),
            .out_ub_y  (ch_ub_y[k+1]),
            .out_rem   (ch_rem[k+1]),
            .out_q     (ch_q[k+1]),
            .out_side  (ch_side[k+1])
        );
    end

    // round half away from zero and apply the sign
    assign d_neg = ch_side[W][CTW+3:CTW];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            rnd[l]    = ({ch_rem[W][l], 1'b0} >= {1'b0, ch_ud[W]});
            qq[l]     = {1'b0, ch_q[W][l]} + (W+1)'(rnd[l]);
            v_next[l] = d_neg[l] ? -VW'(qq[l]) : VW'(qq[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rv_reg        <= ch_valid[W];
            out_valid_reg <= rv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg     <= v_next;
            rside_reg <= ch_side[W];
        end
    end

    // add the offset to A and select each point's source
    assign o_ctrl = ssi_ctrl_t'(rside_reg[CTW-1:0]);
    assign o_by   = rside_reg[CTW+4 +: W];
    assign o_bx   = rside_reg[CTW+4+W +: W];
    assign o_ay   = rside_reg[CTW+4+2*W +: W];
    assign o_ax   = rside_reg[CTW+4+3*W +: W];

    assign pt[0] = W'(VW'(o_ax) + v_reg[0]);
    assign pt[1] = W'(VW'(o_ay) + v_reg[1]);
    assign pt[2] = W'(VW'(o_ax) + v_reg[2]);
    assign pt[3] = W'(VW'(o_ay) + v_reg[3]);

    always_comb
    begin
        case (o_ctrl.near_src)
            SRC_A:
            begin
                near_x_next = o_ax;
                near_y_next = o_ay;
            end
            SRC_B:
            begin
                near_x_next = o_bx;
                near_y_next = o_by;
            end
            default:
            begin
                near_x_next = pt[0];
                near_y_next = pt[1];
            end
        endcase
        case (o_ctrl.far_src)
            SRC_A:
            begin
                far_x_next = o_ax;
                far_y_next = o_ay;
            end
            SRC_B:
            begin
                far_x_next = o_bx;
                far_y_next = o_by;
            end
            default:
            begin
                far_x_next = pt[2];
                far_y_next = pt[3];
            end
        endcase
        if (!o_ctrl.hit)
        begin
            near_x_next = '0;
            near_y_next = '0;
        end
        if (!o_ctrl.has_far)
        begin
            far_x_next = '0;
            far_y_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg     <= o_ctrl.hit;
            has_far_reg <= o_ctrl.has_far;
            near_x_reg  <= near_x_next;
            near_y_reg  <= near_y_next;
            far_x_reg   <= far_x_next;
            far_y_reg   <= far_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign has_far   = has_far_reg;
    assign near_x    = near_x_reg;
    assign near_y    = near_y_reg;
    assign far_x     = far_x_reg;
    assign far_y     = far_y_reg;

    // a far end only comes with a hit
    a_far_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!has_far || hit))
        else $error("far point without hit");

    // no hit gives zero points
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (near_x == '0 && near_y == '0))
        else $error("near point set without hit");

    a_nofar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_far) |-> (far_x == '0 && far_y == '0))
        else $error("far point set without has_far");

    // a held result freezes the rounding stage too
    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(rv_reg))
        else $error("pipeline moved during stall");

endmodule
